>>> sv/hex_octal_field_formatter_defines.svh
// Assertion macros shared by the hex/octal field formatter RTL.
// Self-contained; included by the modules that carry assertions.
`ifndef HEX_OCTAL_FIELD_FORMATTER_DEFINES_SVH
`define HEX_OCTAL_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HOFF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HOFF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/hoff_pkg.sv
// Package for the hex/octal field formatter: codes, constants, FSM state,
// controller/datapath command and status structs, and helper functions.
// No dependencies.
package hoff_pkg;

  localparam int HOFF_MAX_FIELD  = 64;
  localparam int HOFF_MAX_DIGITS = 22;  // 64 bits in octal
  localparam int HOFF_DIG_W      = 5;
  localparam int HOFF_GROUPS     = 6;   // groups of four digits for the scan

  localparam logic [1:0] MODE_HEX_UPPER = 2'd1;
  localparam logic [1:0] MODE_OCTAL     = 2'd2;

  localparam logic [2:0] SIZE_INT   = 3'd0;
  localparam logic [2:0] SIZE_CHAR  = 3'd1;
  localparam logic [2:0] SIZE_SHORT = 3'd2;
  localparam logic [2:0] SIZE_LONG  = 3'd3;
  localparam logic [2:0] SIZE_LLONG = 3'd4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIZE,
    ST_PLAN,
    ST_SEGMENT,
    ST_BOUND,
    ST_EMIT
  } hoff_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic size;
    logic plan;
    logic segment;
    logic bound;
    logic emit;
  } hoff_cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_char;
  } hoff_status_t;

  function automatic logic [63:0] hoff_truncate(input logic [63:0] v,
                                                input logic [2:0]  code);
    logic [63:0] r;
    unique case (code) inside
      SIZE_CHAR:             r = {56'd0, v[7:0]};
      SIZE_SHORT:            r = {48'd0, v[15:0]};
      SIZE_LONG, SIZE_LLONG: r = v;
      SIZE_INT:              r = {32'd0, v[31:0]};
      default:               r = {32'd0, v[31:0]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hoff_ascii(input logic [3:0] d,
                                            input logic       upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'd0, d};
    end else begin
      ch = (upper ? CH_UPPER_A : CH_LOWER_A) + ({4'd0, d} - 8'd10);
    end
    return ch;
  endfunction

endpackage

>>> sv/hoff_in_if.sv
// Input channel of the field formatter: one conversion request per transfer.
// No dependencies.
interface hoff_in_if;
  logic              valid;
  logic              ready;
  logic [63:0]       value;
  logic [2:0]        size_code;
  logic [1:0]        mode;
  logic              left_justify;
  logic              zero_fill;
  logic              alt_form;
  logic [6:0]        field_width;
  logic signed [6:0] digit_precision;

  modport source (output valid, value, size_code, mode, left_justify, zero_fill,
                  alt_form, field_width, digit_precision, input ready);
  modport sink (input valid, value, size_code, mode, left_justify, zero_fill,
                alt_form, field_width, digit_precision, output ready);
endinterface

>>> sv/hoff_out_if.sv
// Output channel of the field formatter: one ASCII character per transfer.
// No dependencies.
interface hoff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       no_output;
  logic       last;

  modport source (output valid, out_char, no_output, last, input ready);
  modport sink (input valid, out_char, no_output, last, output ready);
endinterface

>>> sv/hoff_ctrl.sv
// Sequencing controller of the field formatter: steps one request through
// scan, sizing, planning and character emission. Depends on hoff_pkg.
module hoff_ctrl
  import hoff_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  hoff_status_t status,
  output hoff_cmd_t    cmd
);

  hoff_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SCAN;
      ST_SCAN:    state_next = ST_SIZE;
      ST_SIZE:    state_next = ST_PLAN;
      ST_PLAN:    state_next = ST_SEGMENT;
      ST_SEGMENT: state_next = ST_BOUND;
      ST_BOUND:   state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free && status.final_char) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:    cmd.scan    = 1'b1;
      ST_SIZE:    cmd.size    = 1'b1;
      ST_PLAN:    cmd.plan    = 1'b1;
      ST_SEGMENT: cmd.segment = 1'b1;
      ST_BOUND:   cmd.bound   = 1'b1;
      ST_EMIT:    cmd.emit    = status.out_free;
      default:    cmd         = '0;
    endcase
  end

endmodule

>>> sv/hoff_datapath.sv
// Datapath of the field formatter: request registers, digit-count scan,
// field layout arithmetic, and the output character register.
// Depends on hoff_pkg, hoff_out_if and hex_octal_field_formatter_defines.svh.
`include "hex_octal_field_formatter_defines.svh"

module hoff_datapath
  import hoff_pkg::*;
#(
  parameter int MAX_FIELD = HOFF_MAX_FIELD
) (
  input  logic              clk,
  input  logic              rst,
  input  hoff_cmd_t         cmd,
  output hoff_status_t      status,
  input  logic [63:0]       value,
  input  logic [2:0]        size_code,
  input  logic [1:0]        mode,
  input  logic              left_justify,
  input  logic              zero_fill,
  input  logic              alt_form,
  input  logic [6:0]        field_width,
  input  logic signed [6:0] digit_precision,
  hoff_out_if.source        out_ch
);

  localparam int CW = $clog2(MAX_FIELD + 1);
  localparam int SW = ((CW > 7) ? CW : 7) + 2;

  typedef logic signed [SW-1:0] scnt_t;
  typedef logic [CW-1:0]        cnt_t;

  // Request registers
  logic [63:0] val;
  logic        octal, upper, left, zf, alt;
  scnt_t       width_c, prec;

  // Scan and sizing
  logic [HOFF_GROUPS-1:0]      grp_any, grp_any_c;
  logic [1:0]                  grp_top [HOFF_GROUPS];
  logic [1:0]                  grp_top_c [HOFF_GROUPS];
  logic                        vzero;
  logic [HOFF_DIG_W-1:0]       ndig, ndig_c;

  // Plan
  logic [HOFF_DIG_W-1:0] dcnt;
  scnt_t                 zpad, pad;
  logic                  alt_e, zf_e;

  // Segments and boundaries
  cnt_t       lead, zcnt, trail;
  logic [1:0] npre;
  cnt_t       b1, b2, b3, b4, last_pos, k;
  logic       empty;

  // Output register
  logic       out_valid, out_no_output, out_last;
  logic [7:0] out_char;

  logic [87:0] val88;
  assign val88 = {24'd0, val};

  // Load
  scnt_t width_x, prec_x, max_s, maxp_s;
  always_comb begin
    max_s   = scnt_t'(MAX_FIELD);
    maxp_s  = scnt_t'(MAX_FIELD - 2);
    width_x = $signed(SW'(field_width));
    if (width_x > max_s) width_x = max_s;
    if (digit_precision[6]) begin
      prec_x = scnt_t'(-1);
    end else begin
      prec_x = $signed(SW'(digit_precision[5:0]));
      if (prec_x > maxp_s) prec_x = maxp_s;
    end
  end

  // Per-group highest nonzero digit, four digit slots per group.
  always_comb begin
    logic [3:0] f;
    int         idx;
    for (int g = 0; g < HOFF_GROUPS; g++) begin
      f = '0;
      for (int j = 0; j < 4; j++) begin
        idx = 4 * g + j;
        if (idx < HOFF_MAX_DIGITS) begin
          f[j] = octal ? |val88[3*idx +: 3] : |val88[4*idx +: 4];
        end
      end
      grp_any_c[g] = |f;
      grp_top_c[g] = f[3] ? 2'd3 : (f[2] ? 2'd2 : (f[1] ? 2'd1 : 2'd0));
    end
  end

  // Significant digit count; a zero value still has one digit.
  always_comb begin
    ndig_c = HOFF_DIG_W'(1);
    for (int g = 0; g < HOFF_GROUPS; g++) begin
      if (grp_any[g]) ndig_c = HOFF_DIG_W'(4 * g + int'(grp_top[g]) + 1);
    end
  end

  // Plan arithmetic
  scnt_t                 prec_e, dcnt_s, zpad_c, mx, adj_c, pad_c;
  logic [HOFF_DIG_W-1:0] dcnt_c;
  always_comb begin
    prec_e = (alt && vzero && octal && prec == '0) ? scnt_t'(1) : prec;
    dcnt_c = (vzero && !prec_e[SW-1]) ? '0 : ndig;
    dcnt_s = $signed(SW'(dcnt_c));
    zpad_c = prec_e - dcnt_s;
    mx     = (prec_e > dcnt_s) ? prec_e : dcnt_s;
    adj_c  = '0;
    if (alt && !vzero) begin
      if (!octal)           adj_c = scnt_t'(2);
      else if (zpad_c <= 0) adj_c = scnt_t'(1);
    end
    pad_c = width_c - mx - adj_c;
  end

  // Segment lengths
  cnt_t  padp, zcnt_c;
  scnt_t zpo;
  always_comb begin
    padp   = (pad > 0) ? pad[CW-1:0] : '0;
    zpo    = zpad - ((alt_e && octal) ? scnt_t'(1) : scnt_t'(0));
    zcnt_c = zf_e ? padp : ((zpo > 0) ? zpo[CW-1:0] : '0);
  end

  // Character at the current position
  logic [HOFF_DIG_W-1:0] didx;
  logic [3:0]            digit;
  logic [7:0]            ch;
  cnt_t                  n_c;
  always_comb begin
    didx  = HOFF_DIG_W'(b4 - k - cnt_t'(1));
    digit = octal ? {1'b0, val88[didx*3 +: 3]} : val88[didx*4 +: 4];
    if (k < b1) begin
      ch = CH_SPACE;
    end else if (k < b2) begin
      ch = (k == b1) ? CH_ZERO : (upper ? CH_UPPER_X : CH_LOWER_X);
    end else if (k < b3) begin
      ch = CH_ZERO;
    end else if (k < b4) begin
      ch = hoff_ascii(digit, upper);
    end else begin
      ch = CH_SPACE;
    end
    n_c = b4 + trail;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val     <= hoff_truncate(value, size_code);
      octal   <= (mode == MODE_OCTAL);
      upper   <= (mode == MODE_HEX_UPPER);
      left    <= left_justify;
      zf      <= zero_fill;
      alt     <= alt_form;
      width_c <= width_x;
      prec    <= prec_x;
    end
    if (cmd.scan) begin
      grp_any <= grp_any_c;
      grp_top <= grp_top_c;
    end
    if (cmd.size) begin
      ndig  <= ndig_c;
      vzero <= ~|grp_any;
    end
    if (cmd.plan) begin
      dcnt  <= dcnt_c;
      zpad  <= zpad_c;
      pad   <= pad_c;
      alt_e <= alt && !vzero;
      zf_e  <= zf && prec[SW-1] && !left;
    end
    if (cmd.segment) begin
      lead  <= (!left && !zf_e) ? padp : '0;
      npre  <= alt_e ? (octal ? 2'd1 : 2'd2) : 2'd0;
      zcnt  <= zcnt_c;
      trail <= left ? padp : '0;
      b4    <= cnt_t'(dcnt);
    end
    if (cmd.bound) begin
      // b4 holds the digit count here and becomes the digit end position.
      b1 <= lead;
      b2 <= lead + cnt_t'(npre);
      b3 <= lead + cnt_t'(npre) + zcnt;
      b4 <= lead + cnt_t'(npre) + zcnt + b4;
      k  <= '0;
    end
    if (cmd.emit) begin
      k <= k + cnt_t'(1);
    end
  end

  // The field total is formed in the bound step, while b4 still holds the digit count.
  always_ff @(posedge clk) begin
    if (cmd.bound) begin
      last_pos <= lead + cnt_t'(npre) + zcnt + b4 + trail - cnt_t'(1);
      empty    <= (lead + cnt_t'(npre) + zcnt + b4 + trail) == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char      <= empty ? 8'd0 : ch;
      out_no_output <= empty;
      out_last      <= empty || (k == last_pos);
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.out_char  = out_char;
  assign out_ch.no_output = out_no_output;
  assign out_ch.last      = out_last;

  assign status.out_free   = !out_valid || out_ch.ready;
  assign status.final_char = empty || (k == last_pos) || (k == n_c);

  `HOFF_ASSERT_IMP(a_pos_in_field, clk, rst, cmd.emit && !empty, k <= last_pos, "emit position ran past the end of the field")
  `HOFF_ASSERT_IMP(a_digit_in_range, clk, rst, cmd.emit && !empty && k >= b3 && k < b4, didx < ndig, "digit index beyond the significant digits")
  `HOFF_ASSERT_NXT(a_final_marked, clk, rst, cmd.emit && (empty || k == last_pos), out_valid && out_last, "final character of a field not marked last")
  `HOFF_ASSERT_IMP(a_empty_is_last, clk, rst, out_valid && out_no_output, out_last, "empty-field result not marked last")

endmodule

>>> sv/hex_octal_field_formatter.sv
// Formats one unsigned argument as a printf %x, %X or %o field.
// Requests arrive on in_ch; each request carries the raw value, the length
// modifier, the conversion letter, the flags, the width and the precision.
// The field leaves on out_ch as one ASCII character per transfer, the final
// one flagged by last. An empty field gives a single transfer with no_output
// and last both set.
// After a request transfer the controller steps through scan, size, plan,
// segment and bound, sizing the digits and laying out the field in that fixed
// step sequence, then emits one character per cycle while the output register
// is free; an empty field still takes one transfer.
// in_ch.ready is high only while the block is idle; it may be high while the
// final character of the previous field still waits in the output register.
// When the receiver holds out_ch.ready low, the output register keeps its
// character and emission pauses without loss.
// Synchronous reset returns the controller to idle and drops out_ch.valid.
// Depends on hoff_pkg, hoff_in_if, hoff_out_if, hoff_ctrl and hoff_datapath.
module hex_octal_field_formatter
  import hoff_pkg::*;
#(
  parameter int MAX_FIELD = HOFF_MAX_FIELD
) (
  input logic         clk,
  input logic         rst,
  hoff_in_if.sink     in_ch,
  hoff_out_if.source  out_ch
);

  hoff_cmd_t    cmd;
  hoff_status_t status;
  logic         in_ready;

  assign in_ch.ready = in_ready;

  hoff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hoff_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .value           (in_ch.value),
    .size_code       (in_ch.size_code),
    .mode            (in_ch.mode),
    .left_justify    (in_ch.left_justify),
    .zero_fill       (in_ch.zero_fill),
    .alt_form        (in_ch.alt_form),
    .field_width     (in_ch.field_width),
    .digit_precision (in_ch.digit_precision),
    .out_ch          (out_ch)
  );

endmodule
